[design/amve_pkg.sv]
// Shared types and constants for the adjacency matrix vertex/arc edit block.
package amve_pkg;

    // Geometry
    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = 64;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;

    // Cycles from request acceptance until the selected row reaches the chain tail
    localparam int LOAD_AT = MAX_VERTICES + 1;
    localparam int WAIT_W  = $clog2(LOAD_AT + 1);

    // Request codes carried in s_axis tuser
    typedef enum logic [2:0] {
        REQ_INS_VERTEX = 3'd0,
        REQ_INS_ARC    = 3'd1,
        REQ_DEL_VERTEX = 3'd2,
        REQ_DEL_ARC    = 3'd3,
        REQ_READ_ROW   = 3'd4
    } t_req;

    // Operation broadcast to every row cell
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_CLEAR,
        CELL_SET,
        CELL_UNSET,
        CELL_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] p;     // target position (row, or column for clear/delete)
        logic [POS_W-1:0] q;     // arc column
        logic [POS_W-1:0] last;  // last active position before a delete
        logic [POS_W-1:0] sel;   // row picked up by the readout chain
    } t_cell_cmd;

endpackage

[design/adjacency_matrix_vertex_arc_edit.sv]
// Top level: directed graph adjacency matrix with vertex and arc edit requests.
//
// Requests arrive on the s_axis channel: tuser carries the request type, tdata the
// source/deleted/read vertex and the arc destination vertex. Each request yields one
// result transfer on m_axis: the addressed row (active columns only) and the vertex
// count in tdata, the range error flag in tuser.
// The matrix is a column of row cells. An edit is applied to all cells at once
// (a vertex delete moves each row up from its neighbor and drops the column in
// place); the addressed row then travels down the readout chain of cells, one cell
// per cycle. The result is loaded when the row reaches the chain tail, and the next
// request is accepted only after that load, so one request is worked on at a time
// and the pace is set by the readout chain length.
// The result sits in an output register, so a stalled receiver does not block the
// next request from being accepted; that request then holds at its end until the
// register frees, and the input stalls behind it. Reset (synchronous, active low)
// clears the matrix, the vertex count and both configuration registers at once.
// The APB port (index_base at 0x0, initial_vertex_count at 0x4, which also loads
// the count) is for the user to write only while idle; the block does not enforce it.
module adjacency_matrix_vertex_arc_edit import amve_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // vertex_a[6:0], vertex_b[13:7], zero[15:14]
    input  logic [2:0]  i_s_axis_tuser,   // req_type[2:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // row_bits[63:0], vertex_total[70:64], zero[71]
    output logic        o_m_axis_tuser,   // range_error[0]
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_cell_cmd        cmd;
    logic [ROW_W-1:0] w_row  [MAX_VERTICES];
    logic [ROW_W-1:0] w_pass [MAX_VERTICES];
    logic [ROW_W-1:0] row_bits;
    logic [CNT_W-1:0] vertex_total;

    amve_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_s_axis_tvalid),
        .o_req_ready    (o_s_axis_tready),
        .i_req_type     (i_s_axis_tuser),
        .i_vertex_a     (i_s_axis_tdata[6:0]),
        .i_vertex_b     (i_s_axis_tdata[13:7]),
        .o_res_valid    (o_m_axis_tvalid),
        .i_res_ready    (i_m_axis_tready),
        .o_row_bits     (row_bits),
        .o_vertex_total (vertex_total),
        .o_range_error  (o_m_axis_tuser),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_cmd          (cmd),
        .i_tail_pass    (w_pass[MAX_VERTICES-1])
    );

    // Row cells: row data moves up on delete, readout moves down each cycle
    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        logic [ROW_W-1:0] nbr_row;
        logic [ROW_W-1:0] pass_in;

        if (i == MAX_VERTICES - 1) begin : g_tail
            assign nbr_row = '0;
        end else begin : g_body
            assign nbr_row = w_row[i+1];
        end

        if (i == 0) begin : g_head
            assign pass_in = '0;
        end else begin : g_rest
            assign pass_in = w_pass[i-1];
        end

        amve_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (POS_W'(i)),
            .i_cmd     (cmd),
            .i_nbr_row (nbr_row),
            .i_pass    (pass_in),
            .o_row     (w_row[i]),
            .o_pass    (w_pass[i])
        );
    end

    assign o_m_axis_tdata = {1'b0, vertex_total, row_bits};
    assign o_pready       = 1'b1;

endmodule

[design/amve_cell.sv]
// One matrix row cell: holds a row, edits it, shifts it up on delete, forwards readout.
module amve_cell import amve_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_idx,
    input  t_cell_cmd        i_cmd,
    input  logic [ROW_W-1:0] i_nbr_row,  // row of the next cell down
    input  logic [ROW_W-1:0] i_pass,     // readout from the previous cell
    output logic [ROW_W-1:0] o_row,
    output logic [ROW_W-1:0] o_pass
);

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_pass;
    logic [ROW_W-1:0] n_row;
    logic [ROW_W-1:0] bit_p;
    logic [ROW_W-1:0] bit_q;
    logic [ROW_W-1:0] bit_last;
    logic [ROW_W-1:0] low_mask;
    logic [ROW_W-1:0] del_src;
    logic [ROW_W-1:0] dropped;

    assign bit_p    = ROW_W'(1) << i_cmd.p;
    assign bit_q    = ROW_W'(1) << i_cmd.q;
    assign bit_last = ROW_W'(1) << i_cmd.last;
    assign low_mask = bit_p - ROW_W'(1);

    // Delete: rows from p up to but not including last take the neighbor's row, then column p is removed
    assign del_src = (i_idx >= i_cmd.p && i_idx < i_cmd.last) ? i_nbr_row : r_row;
    assign dropped = (del_src & low_mask) | ((del_src >> 1) & ~low_mask);

    always_comb begin
        n_row = r_row;
        case (i_cmd.op)
            CELL_CLEAR: begin
                n_row = (i_idx == i_cmd.p) ? '0 : (r_row & ~bit_p);
            end
            CELL_SET: begin
                if (i_idx == i_cmd.p) n_row = r_row | bit_q;
            end
            CELL_UNSET: begin
                if (i_idx == i_cmd.p) n_row = r_row & ~bit_q;
            end
            CELL_DEL: begin
                n_row = (i_idx == i_cmd.last) ? '0 : (dropped & ~bit_last);
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    // Row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // Readout chain: inject own row when selected, else forward
    always_ff @(posedge i_clk) begin
        r_pass <= (i_idx == i_cmd.sel) ? r_row : i_pass;
    end

    assign o_row  = r_row;
    assign o_pass = r_pass;

endmodule

[design/amve_ctrl.sv]
// Request decode, vertex count, configuration registers and result register.
module amve_ctrl import amve_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [2:0]       i_req_type,
    input  logic [6:0]       i_vertex_a,
    input  logic [6:0]       i_vertex_b,
    // result
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [ROW_W-1:0] o_row_bits,
    output logic [CNT_W-1:0] o_vertex_total,
    output logic             o_range_error,
    // configuration
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    // row cells
    output t_cell_cmd        o_cmd,
    input  logic [ROW_W-1:0] i_tail_pass
);

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } t_state;

    t_state           r_state;
    logic [WAIT_W-1:0] r_wait;
    t_cell_cmd        r_cmd;
    logic             r_err;
    logic             r_sel_ok;
    logic [CNT_W-1:0] r_count;
    logic [5:0]       r_base;
    logic [CNT_W-1:0] r_init_cnt;
    logic             r_res_valid;
    logic [ROW_W-1:0] r_row_bits;
    logic [CNT_W-1:0] r_vertex_total;
    logic             r_range_error;

    logic             accept;
    logic             cfg_wr;
    logic [CNT_W-1:0] cfg_cnt;
    logic [6:0]       base_ext;
    logic [6:0]       diff_a;
    logic [6:0]       diff_b;
    logic             ge_a;
    logic             ok_a;
    logic             ok_b;
    t_cell_op         n_op;
    logic [POS_W-1:0] n_p;
    logic [CNT_W-1:0] n_count;
    logic             n_err;
    logic             res_free;
    logic             res_load;
    logic [ROW_W-1:0] active_mask;

    assign accept   = i_req_valid && (r_state == ST_IDLE);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign res_free = !r_res_valid || i_res_ready;
    assign res_load = (r_state == ST_WAIT) && (r_wait == WAIT_W'(LOAD_AT)) && res_free;

    // Saturate the configured count at the matrix size
    assign cfg_cnt = (i_pwdata[6:0] > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : i_pwdata[6:0];

    // Absolute vertex number to matrix position
    assign base_ext = {1'b0, r_base};
    assign diff_a   = i_vertex_a - base_ext;
    assign diff_b   = i_vertex_b - base_ext;
    assign ge_a     = i_vertex_a >= base_ext;
    assign ok_a     = ge_a && (diff_a < r_count);
    assign ok_b     = (i_vertex_b >= base_ext) && (diff_b < r_count);

    // Request decode
    always_comb begin
        n_op    = CELL_NOP;
        n_p     = diff_a[POS_W-1:0];
        n_count = r_count;
        n_err   = 1'b0;
        case (t_req'(i_req_type))
            REQ_INS_VERTEX: begin
                if (r_count >= CNT_W'(MAX_VERTICES)) begin
                    n_err = 1'b1;
                end else begin
                    n_op    = CELL_CLEAR;
                    n_p     = r_count[POS_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_INS_ARC, REQ_DEL_ARC: begin
                if (!(ok_a && ok_b)) begin
                    n_err = 1'b1;
                end else begin
                    n_op = (t_req'(i_req_type) == REQ_INS_ARC) ? CELL_SET : CELL_UNSET;
                end
            end
            REQ_DEL_VERTEX: begin
                if (!ok_a) begin
                    n_err = 1'b1;
                end else begin
                    n_op    = CELL_DEL;
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_READ_ROW: begin
                n_err = !ok_a;
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // Only columns of active vertices are shown
    assign active_mask = (r_count >= CNT_W'(ROW_W)) ? '1
                       : ((ROW_W'(1) << r_count[POS_W-1:0]) - ROW_W'(1));

    // Sequencer, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= '0;
            r_cmd       <= '{op: CELL_NOP, p: '0, q: '0, last: '0, sel: '0};
            r_err       <= 1'b0;
            r_sel_ok    <= 1'b0;
            r_count     <= '0;
            r_base      <= '0;
            r_init_cnt  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (!i_paddr[2]) begin
                    r_base <= i_pwdata[5:0];
                end else begin
                    r_init_cnt <= cfg_cnt;
                    r_count    <= cfg_cnt;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd.op   <= n_op;
                        r_cmd.p    <= n_p;
                        r_cmd.q    <= diff_b[POS_W-1:0];
                        r_cmd.last <= POS_W'(r_count - CNT_W'(1));
                        r_cmd.sel  <= diff_a[POS_W-1:0];
                        r_sel_ok   <= ge_a && (diff_a < n_count);
                        r_err      <= n_err;
                        r_count    <= n_count;
                        r_wait     <= '0;
                        r_state    <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    // the edit is applied in the first wait cycle only
                    r_cmd.op <= CELL_NOP;
                    if (r_wait != WAIT_W'(LOAD_AT)) begin
                        r_wait <= r_wait + WAIT_W'(1);
                    end else if (res_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_row_bits     <= r_sel_ok ? (i_tail_pass & active_mask) : '0;
            r_vertex_total <= r_count;
            r_range_error  <= r_err;
        end
    end

    assign o_req_ready    = (r_state == ST_IDLE);
    assign o_res_valid    = r_res_valid;
    assign o_row_bits     = r_row_bits;
    assign o_vertex_total = r_vertex_total;
    assign o_range_error  = r_range_error;
    assign o_cmd          = r_cmd;
    assign o_prdata       = i_paddr[2] ? {25'd0, r_init_cnt} : {26'd0, r_base};

endmodule

[tb/testbench.sv]
// Self-checking testbench for the adjacency matrix vertex/arc edit block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import amve_pkg::*;

    // Request codes outside the defined set
    localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

    // Register byte addresses
    localparam logic [2:0] ADDR_INDEX_BASE = 3'h0;
    localparam logic [2:0] ADDR_INIT_COUNT = 3'h4;

    // ~1525 requests with random gaps and receiver hold-offs, plus one long hold
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int LONG_HOLD       = 400;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int MAX_PRINTED     = 200;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] total;
        logic             err;
    } t_row_result;

    typedef enum { STEP_REQ, STEP_CFG } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [2:0]  req;
        logic [6:0]  va;
        logic [6:0]  vb;
        logic [2:0]  addr;
        logic [31:0] data;
        bit          typed;
        t_row_result want;
    } t_dir_step;

    // DUT connections, all driven to known values from time zero
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Graph predictor state
    logic [ROW_W-1:0] graph_rows [MAX_VERTICES];
    int graph_count;
    int graph_base;

    // Expected results, oldest first
    t_row_result pending_rows [$];
    t_dir_step   dir_steps [$];

    // Run control shared between processes
    bit idle_on       = 1'b1;
    bit burst_mode    = 1'b0;
    bit long_hold_req = 1'b0;
    int n_sent        = 0;
    int n_directed    = 0;
    int n_results     = 0;
    int n_cfg         = 0;
    int n_mismatch    = 0;
    int n_long_holds  = 0;
    int cycle_cnt     = 0;

    adjacency_matrix_vertex_arc_edit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    // Matrix position of an absolute vertex, -1 when not active
    function automatic int vertex_slot(logic [6:0] v);
        int d;
        d = int'(v) - graph_base;
        if (d < 0 || d >= graph_count) return -1;
        return d;
    endfunction

    function automatic logic [ROW_W-1:0] live_mask();
        if (graph_count >= MAX_VERTICES) return '1;
        return (64'd1 << graph_count) - 64'd1;
    endfunction

    // Zero one position's row and its column in every row
    function automatic void blank_vertex(int p);
        graph_rows[p] = '0;
        foreach (graph_rows[i]) graph_rows[i][p] = 1'b0;
    endfunction

    // Drop column p from a row, higher columns move down by one
    function automatic logic [ROW_W-1:0] squeeze_column(logic [ROW_W-1:0] r, int p);
        logic [ROW_W-1:0] low;
        logic [ROW_W-1:0] high;
        low  = r & ((64'd1 << p) - 64'd1);
        high = (p < ROW_W - 1) ? ((r >> (p + 1)) << p) : '0;
        return low | high;
    endfunction

    function automatic void remove_vertex(int p);
        int last;
        last = graph_count - 1;
        for (int i = p; i < last; i++) graph_rows[i] = graph_rows[i + 1];
        foreach (graph_rows[i]) graph_rows[i] = squeeze_column(graph_rows[i], p);
        blank_vertex(last);
        graph_count--;
    endfunction

    // Apply one request to the graph and return the result it should produce
    function automatic t_row_result graph_apply(logic [2:0] req, logic [6:0] va,
                                                logic [6:0] vb);
        t_row_result res;
        int pa;
        int pb;
        logic err;
        pa  = vertex_slot(va);
        pb  = vertex_slot(vb);
        err = 1'b0;
        case (req)
            REQ_INS_VERTEX: begin
                if (graph_count >= MAX_VERTICES) begin
                    err = 1'b1;
                end else begin
                    blank_vertex(graph_count);
                    graph_count++;
                end
            end
            REQ_INS_ARC, REQ_DEL_ARC: begin
                if (pa < 0 || pb < 0) err = 1'b1;
                else if (req == REQ_INS_ARC) graph_rows[pa][pb] = 1'b1;
                else graph_rows[pa][pb] = 1'b0;
            end
            REQ_DEL_VERTEX: begin
                if (pa < 0) err = 1'b1;
                else remove_vertex(pa);
            end
            REQ_READ_ROW: err = (pa < 0);
            default: err = 1'b1;
        endcase
        // row is judged after the operation
        pa = vertex_slot(va);
        res.row   = (pa < 0) ? '0 : (graph_rows[pa] & live_mask());
        res.total = graph_count[CNT_W-1:0];
        res.err   = err;
        return res;
    endfunction

    function automatic void graph_config(logic [2:0] addr, logic [31:0] data);
        int v;
        if (addr == ADDR_INDEX_BASE) begin
            graph_base = int'(data[5:0]);
        end else if (addr == ADDR_INIT_COUNT) begin
            v = int'(data[6:0]);
            graph_count = (v > MAX_VERTICES) ? MAX_VERTICES : v;
        end
    endfunction

    // Mostly active vertices, sometimes anything the field allows
    function automatic logic [6:0] pick_vertex();
        if (graph_count > 0 && $urandom_range(0, 9) < 8)
            return 7'(graph_base + $urandom_range(0, graph_count - 1));
        return 7'($urandom_range(0, 127));
    endfunction

    // ---------------- drivers ----------------

    // Offer one request; expectation is recorded at the accepting edge
    task automatic send_request(input logic [2:0] req, input logic [6:0] va,
                                input logic [6:0] vb, input bit typed,
                                input t_row_result want);
        int gap;
        t_row_result calc;
        gap = (idle_on && !burst_mode) ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, vb, va};
        s_tuser  <= req;
        do @(posedge i_clk); while (!s_tready);
        calc = graph_apply(req, va, vb);
        pending_rows.push_back(typed ? want : calc);
        n_sent++;
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        graph_config(addr, data);
        n_cfg++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random(input bit grow);
        int r;
        int ins_w;
        logic [2:0] req;
        logic [6:0] va;
        logic [6:0] vb;
        t_row_result unused;
        unused = '{default: '0};
        ins_w  = grow ? 16 : 6;
        r      = $urandom_range(0, 99);
        if (r < ins_w) req = REQ_INS_VERTEX;
        else if (r < 22) req = REQ_DEL_VERTEX;
        else if (r < 57) req = REQ_INS_ARC;
        else if (r < 72) req = REQ_DEL_ARC;
        else if (r < 95) req = REQ_READ_ROW;
        else req = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
        va = pick_vertex();
        vb = pick_vertex();
        send_request(req, va, vb, 1'b0, unused);
    endtask

    function automatic void add_req(logic [2:0] req, logic [6:0] va, logic [6:0] vb,
                                    bit typed, logic [ROW_W-1:0] row,
                                    logic [CNT_W-1:0] total, logic err);
        t_dir_step st;
        st.kind       = STEP_REQ;
        st.req        = req;
        st.va         = va;
        st.vb         = vb;
        st.addr       = '0;
        st.data       = '0;
        st.typed      = typed;
        st.want.row   = row;
        st.want.total = total;
        st.want.err   = err;
        dir_steps.push_back(st);
    endfunction

    function automatic void add_cfg(logic [2:0] addr, logic [31:0] data);
        t_dir_step st;
        st.kind       = STEP_CFG;
        st.req        = '0;
        st.va         = '0;
        st.vb         = '0;
        st.addr       = addr;
        st.data       = data;
        st.typed      = 1'b0;
        st.want.row   = '0;
        st.want.total = '0;
        st.want.err   = 1'b0;
        dir_steps.push_back(st);
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTED)
            $display("MISMATCH result %0d %s: got %h expected %h",
                     n_results, field, got, want);
    endtask

    // Result receiver: random hold-offs, compares each transfer with the oldest expectation
    initial begin : result_sink
        int stall;
        t_row_result exp_r;
        forever begin
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (long_hold_req) begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
                n_long_holds++;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            n_results++;
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                exp_r = pending_rows.pop_front();
                if (m_tdata[63:0] !== exp_r.row)
                    report_mismatch("row_bits", m_tdata[63:0], exp_r.row);
                if (m_tdata[70:64] !== exp_r.total)
                    report_mismatch("vertex_total", 64'(m_tdata[70:64]),
                                    64'(exp_r.total));
                if (m_tuser !== exp_r.err)
                    report_mismatch("range_error", 64'(m_tuser), 64'(exp_r.err));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("adjacency_matrix_vertex_arc_edit test failed");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin : main_seq
        t_dir_step st;
        int base_val;
        int cnt_val;
        bit grow;
        foreach (graph_rows[i]) graph_rows[i] = '0;
        graph_count = 0;
        graph_base  = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset state (base 0, no vertices)
        add_req(REQ_READ_ROW,   7'd0,   7'd0,   1, 64'd0, 7'd0, 1'b1);  // empty graph
        add_req(REQ_INS_VERTEX, 7'd0,   7'd0,   1, 64'd0, 7'd1, 1'b0);
        add_req(REQ_INS_ARC,    7'd0,   7'd0,   1, 64'd1, 7'd1, 1'b0);  // self loop
        add_req(REQ_INS_ARC,    7'd0,   7'd1,   1, 64'd1, 7'd1, 1'b1);  // dest not active
        add_req(REQ_READ_ROW,   7'd127, 7'd0,   1, 64'd0, 7'd1, 1'b1);
        add_req(REQ_RSVD_FIRST, 7'd0,   7'd0,   1, 64'd1, 7'd1, 1'b1);  // unknown request
        add_req(REQ_RSVD_LAST,  7'd127, 7'd127, 1, 64'd0, 7'd1, 1'b1);
        add_req(REQ_DEL_ARC,    7'd0,   7'd0,   1, 64'd0, 7'd1, 1'b0);
        add_req(REQ_DEL_VERTEX, 7'd0,   7'd0,   1, 64'd0, 7'd0, 1'b0);
        add_req(REQ_DEL_VERTEX, 7'd0,   7'd0,   1, 64'd0, 7'd0, 1'b1);  // nothing to delete
        // Highest base, count written above the maximum saturates to full
        add_cfg(ADDR_INDEX_BASE, 32'd63);
        add_cfg(ADDR_INIT_COUNT, 32'd127);
        add_req(REQ_INS_VERTEX, 7'd63,  7'd0,   1, 64'd0, 7'd64, 1'b1);  // full
        add_req(REQ_INS_ARC,    7'd63,  7'd126, 1, 64'h8000_0000_0000_0000, 7'd64, 1'b0);
        add_req(REQ_INS_ARC,    7'd126, 7'd63,  1, 64'd1, 7'd64, 1'b0);
        add_req(REQ_INS_ARC,    7'd62,  7'd63,  1, 64'd0, 7'd64, 1'b1);  // below base
        add_req(REQ_INS_ARC,    7'd63,  7'd127, 1, 64'h8000_0000_0000_0000, 7'd64, 1'b1);
        add_req(REQ_INS_ARC,    7'd100, 7'd100, 0, '0, '0, 1'b0);
        add_req(REQ_DEL_VERTEX, 7'd63,  7'd0,   0, '0, '0, 1'b0);  // first row, shifts all
        add_req(REQ_READ_ROW,   7'd125, 7'd0,   0, '0, '0, 1'b0);
        add_req(REQ_DEL_VERTEX, 7'd125, 7'd0,   0, '0, '0, 1'b0);  // last active row
        add_req(REQ_READ_ROW,   7'd126, 7'd0,   0, '0, '0, 1'b0);
        // Count back to zero; matrix keeps stale contents
        add_cfg(ADDR_INIT_COUNT, 32'd0);
        add_req(REQ_INS_ARC,    7'd63,  7'd63,  1, 64'd0, 7'd0, 1'b1);
        add_req(REQ_DEL_VERTEX, 7'd63,  7'd0,   1, 64'd0, 7'd0, 1'b1);
        add_req(REQ_INS_VERTEX, 7'd0,   7'd0,   1, 64'd0, 7'd1, 1'b0);  // shown row below base
        add_req(REQ_INS_VERTEX, 7'd63,  7'd0,   0, '0, '0, 1'b0);
        add_req(REQ_READ_ROW,   7'd64,  7'd0,   0, '0, '0, 1'b0);

        foreach (dir_steps[i]) begin
            st = dir_steps[i];
            if (st.kind == STEP_CFG) begin
                wait_drained();
                apb_write(st.addr, st.data);
            end else begin
                send_request(st.req, st.va, st.vb, st.typed, st.want);
            end
        end
        n_directed = n_sent;

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin base_val = 0;  cnt_val = 64; grow = 1'b0; end
                1: begin base_val = 63; cnt_val = 1;  grow = 1'b1; end
                3: begin base_val = 17; cnt_val = 40; grow = 1'b0; end
                4: begin base_val = 0;  cnt_val = 0;  grow = 1'b1; end
                default: begin
                    base_val = $urandom_range(0, 63);
                    cnt_val  = $urandom_range(0, 127);
                    grow     = 1'($urandom_range(0, 1));
                end
            endcase
            apb_write(ADDR_INDEX_BASE, 32'(base_val));
            apb_write(ADDR_INIT_COUNT, 32'(cnt_val));
            idle_on = (ph != 2);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // back-to-back requests against a long receiver hold-off
                burst_mode = (ph == 3 && k < 24);
                if (ph == 3 && k == 0) long_hold_req = 1'b1;
                send_random(grow);
            end
            burst_mode = 1'b0;
        end
        idle_on = 1'b1;

        wait_drained();
        repeat (MAX_VERTICES + 8) @(posedge i_clk);

        $display("Run covered %0d requests (%0d directed), %0d results, %0d register writes",
                 n_sent, n_directed, n_results, n_cfg);
        $display("%0d long receiver hold-off(s), %0d cycles, %0d mismatches",
                 n_long_holds, cycle_cnt, n_mismatch);
        if (n_mismatch == 0 && pending_rows.size() == 0) begin
            $display("adjacency_matrix_vertex_arc_edit test passed");
        end else begin
            $display("adjacency_matrix_vertex_arc_edit test failed");
        end
        $finish;
    end

endmodule
